>>> hdl/cube_sphere_vertex_and_index_gen_macros.svh
// Assertion macros for the cube-sphere vertex and index generator.
// Used by the top level only; needs signals named clock and reset in scope.
`ifndef CUBE_SPHERE_VERTEX_AND_INDEX_GEN_MACROS_SVH
`define CUBE_SPHERE_VERTEX_AND_INDEX_GEN_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSVIG_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define CSVIG_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/csvig_pkg.sv
// Package for the cube-sphere vertex and index generator.
// Types, widths and constants shared by all modules; no dependencies.
`default_nettype none
package csvig_pkg;
   localparam int MAX_RESOLUTION_DEFAULT  = 256;
   localparam int COORD_FRAC_BITS_DEFAULT = 15;

   localparam int RES_W  = 9;
   localparam int GRID_W = 8;
   localparam int FACE_W = 3;
   localparam int POS_W  = 16;
   localparam int IDX_W  = 19;
   localparam int VEC_W  = 11;   // 2*col - d, signed
   localparam int MAG_W  = 10;
   localparam int SQ_W   = 18;
   localparam int SUM_W  = 20;
   localparam int FR_W   = 13;   // face*res + row
   localparam int N_W    = 23;   // vertex number before masking

   localparam logic [RES_W-1:0] RESOLUTION_RESET = 9'd16;
   localparam logic [RES_W-1:0] RESOLUTION_MIN   = 9'd2;

   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd5;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic [GRID_W-1:0] col;
      logic [GRID_W-1:0] row;
   } req_type;

   typedef struct packed {
      logic              quad_valid;
      logic [IDX_W-1:0]  tri_a0;
      logic [IDX_W-1:0]  tri_a1;
      logic [IDX_W-1:0]  tri_a2;
      logic [IDX_W-1:0]  tri_b0;
      logic [IDX_W-1:0]  tri_b1;
      logic [IDX_W-1:0]  tri_b2;
   } idx_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    quad_valid;
      logic [IDX_W-1:0]        tri_a0;
      logic [IDX_W-1:0]        tri_a1;
      logic [IDX_W-1:0]        tri_a2;
      logic [IDX_W-1:0]        tri_b0;
      logic [IDX_W-1:0]        tri_b1;
      logic [IDX_W-1:0]        tri_b2;
   } rsp_type;
endpackage
`default_nettype wire

>>> hdl/csvig_front.sv
// Front end: clamps, face vector, squares, sum and quad indices in three stages.
// Depends on csvig_pkg.
`default_nettype none
module csvig_front #(
   parameter int MAX_RESOLUTION  = csvig_pkg::MAX_RESOLUTION_DEFAULT,
   parameter int COORD_FRAC_BITS = csvig_pkg::COORD_FRAC_BITS_DEFAULT,
   localparam int TW = csvig_pkg::SQ_W + 2 * COORD_FRAC_BITS + 2
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire csvig_pkg::req_type                  in_data,
   output logic                                     in_ready,
   input  wire logic [csvig_pkg::RES_W-1:0]         res,
   output logic                                     out_valid,
   output logic [csvig_pkg::SUM_W-1:0]              out_s,
   output logic [2:0]                               out_neg,
   output logic [2:0][TW-1:0]                       out_t,
   output csvig_pkg::idx_type                       out_idx,
   input  wire logic                                out_ready
);
   localparam int RW = csvig_pkg::RES_W;
   localparam int GW = csvig_pkg::GRID_W;
   localparam int VW = csvig_pkg::VEC_W;

   // stage 1
   logic                                  v1_ff;
   logic [csvig_pkg::FACE_W-1:0]          face1_ff;
   logic [GW-1:0]                         col1_ff;
   logic [RW-1:0]                         res1_ff;
   logic signed [2:0][VW-1:0]             vec1_ff;
   logic [csvig_pkg::FR_W-1:0]            fr1_ff;
   logic                                  quad1_ff;
   // stage 2
   logic                                  v2_ff;
   logic [2:0][csvig_pkg::SQ_W-1:0]       sq2_ff;
   logic [2:0]                            neg2_ff;
   logic [csvig_pkg::N_W-1:0]             n2_ff;
   logic [RW-1:0]                         res2_ff;
   logic                                  inv2_ff;
   logic                                  quad2_ff;
   // stage 3
   logic                                  v3_ff;

   logic adv1, adv2, adv3;
   assign adv3 = !v3_ff || out_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign in_ready = adv1;
   assign out_valid = v3_ff;

   // stage 1 logic
   logic [RW-1:0]                res_c, d_c;
   logic [GW-1:0]                col_c, row_c;
   logic [csvig_pkg::FACE_W-1:0] face_c;
   logic signed [VW-1:0]         a_c, b_c, dd_c;
   logic signed [2:0][VW-1:0]    vec_c;

   always_comb begin
      if (res < csvig_pkg::RESOLUTION_MIN) begin
         res_c = csvig_pkg::RESOLUTION_MIN;
      end else if (int'(res) > MAX_RESOLUTION) begin
         res_c = RW'(MAX_RESOLUTION);
      end else begin
         res_c = res;
      end
      d_c = res_c - RW'(1);
      col_c = ({1'b0, in_data.col} > d_c) ? d_c[GW-1:0] : in_data.col;
      row_c = ({1'b0, in_data.row} > d_c) ? d_c[GW-1:0] : in_data.row;
      face_c = (in_data.face > csvig_pkg::FACE_NEG_X) ? csvig_pkg::FACE_POS_Z : in_data.face;
      a_c  = $signed({2'b00, col_c, 1'b0}) - $signed({2'b00, d_c});
      b_c  = $signed({2'b00, row_c, 1'b0}) - $signed({2'b00, d_c});
      dd_c = $signed({2'b00, d_c});
      unique case (face_c)
         csvig_pkg::FACE_NEG_Z: vec_c = {-dd_c, b_c, a_c};
         csvig_pkg::FACE_POS_Y: vec_c = {b_c, dd_c, a_c};
         csvig_pkg::FACE_NEG_Y: vec_c = {b_c, -dd_c, a_c};
         csvig_pkg::FACE_POS_X: vec_c = {a_c, b_c, dd_c};
         csvig_pkg::FACE_NEG_X: vec_c = {a_c, b_c, -dd_c};
         default:               vec_c = {dd_c, b_c, a_c};
      endcase
   end

   // stage 2 logic: lane 0 is x, 1 is y, 2 is z
   logic [2:0][csvig_pkg::MAG_W-1:0] mag_c;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag_c[k] = vec1_ff[k][VW-1] ? csvig_pkg::MAG_W'(-vec1_ff[k])
                                     : csvig_pkg::MAG_W'(vec1_ff[k]);
      end
   end

   // stage 3 logic
   logic [csvig_pkg::N_W-1:0] n_r1, n_r;
   csvig_pkg::idx_type idx_c;
   always_comb begin
      n_r1 = n2_ff + csvig_pkg::N_W'(res2_ff) + csvig_pkg::N_W'(1);
      n_r  = n2_ff + csvig_pkg::N_W'(res2_ff);
      idx_c = '0;
      if (quad2_ff) begin
         idx_c.quad_valid = 1'b1;
         idx_c.tri_a0 = n2_ff[csvig_pkg::IDX_W-1:0];
         idx_c.tri_b0 = n2_ff[csvig_pkg::IDX_W-1:0];
         if (inv2_ff) begin
            idx_c.tri_a1 = n_r1[csvig_pkg::IDX_W-1:0];
            idx_c.tri_a2 = n_r[csvig_pkg::IDX_W-1:0];
            idx_c.tri_b1 = csvig_pkg::IDX_W'(n2_ff + csvig_pkg::N_W'(1));
            idx_c.tri_b2 = n_r1[csvig_pkg::IDX_W-1:0];
         end else begin
            idx_c.tri_a1 = n_r[csvig_pkg::IDX_W-1:0];
            idx_c.tri_a2 = n_r1[csvig_pkg::IDX_W-1:0];
            idx_c.tri_b1 = n_r1[csvig_pkg::IDX_W-1:0];
            idx_c.tri_b2 = csvig_pkg::IDX_W'(n2_ff + csvig_pkg::N_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
      if (adv1) begin
         face1_ff <= face_c;
         col1_ff  <= col_c;
         res1_ff  <= res_c;
         vec1_ff  <= vec_c;
         fr1_ff   <= csvig_pkg::FR_W'(face_c) * csvig_pkg::FR_W'(res_c)
                   + csvig_pkg::FR_W'(row_c);
         quad1_ff <= ({1'b0, col_c} < d_c) && ({1'b0, row_c} < d_c);
      end
      if (adv2) begin
         for (int k = 0; k < 3; k++) begin
            sq2_ff[k]  <= csvig_pkg::SQ_W'(mag_c[k]) * csvig_pkg::SQ_W'(mag_c[k]);
            neg2_ff[k] <= vec1_ff[k][VW-1];
         end
         n2_ff    <= csvig_pkg::N_W'(fr1_ff) * csvig_pkg::N_W'(res1_ff)
                   + csvig_pkg::N_W'(col1_ff);
         res2_ff  <= res1_ff;
         inv2_ff  <= (face1_ff == csvig_pkg::FACE_NEG_Z) || (face1_ff == csvig_pkg::FACE_POS_Y)
                  || (face1_ff == csvig_pkg::FACE_POS_X);
         quad2_ff <= quad1_ff;
      end
      if (adv3) begin
         out_s <= csvig_pkg::SUM_W'(sq2_ff[0]) + csvig_pkg::SUM_W'(sq2_ff[1])
                + csvig_pkg::SUM_W'(sq2_ff[2]);
         for (int k = 0; k < 3; k++) begin
            out_t[k] <= {sq2_ff[k], (2 * COORD_FRAC_BITS + 2)'(0)};
         end
         out_neg <= neg2_ff;
         out_idx <= idx_c;
      end
   end
endmodule
`default_nettype wire

>>> hdl/csvig_norm_stage.sv
// One bit of the normalize search for all three lanes, with its own register.
// Depends on csvig_pkg.
`default_nettype none
module csvig_norm_stage #(
   parameter int COORD_FRAC_BITS = csvig_pkg::COORD_FRAC_BITS_DEFAULT,
   parameter int BIT_POS         = 0,
   localparam int TW = csvig_pkg::SQ_W + 2 * COORD_FRAC_BITS + 2,
   localparam int PW = 2 * COORD_FRAC_BITS + 26,
   localparam int RW = COORD_FRAC_BITS + 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [csvig_pkg::SUM_W-1:0]   in_s,
   input  wire logic [2:0]                    in_neg,
   input  wire logic [2:0][TW-1:0]            in_t,
   input  wire logic signed [2:0][PW:0]       in_p,
   input  wire logic signed [2:0][PW:0]       in_q,
   input  wire logic [2:0][RW-1:0]            in_r,
   input  wire csvig_pkg::idx_type            in_idx,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [csvig_pkg::SUM_W-1:0]        out_s,
   output logic [2:0]                         out_neg,
   output logic [2:0][TW-1:0]                 out_t,
   output logic signed [2:0][PW:0]            out_p,
   output logic signed [2:0][PW:0]            out_q,
   output logic [2:0][RW-1:0]                 out_r,
   output csvig_pkg::idx_type                 out_idx
);
   // P tracks (2r-1)^2 * S and Q tracks (2r-1) * S; trying a bit only needs adds
   logic signed [PW:0] s_ext;
   logic signed [2:0][PW:0] cand_p, next_p, next_q;
   logic [2:0][RW-1:0] next_r;
   logic adv;

   assign adv = !out_valid || out_ready;
   assign in_ready = adv;
   assign s_ext = $signed({(PW + 1 - csvig_pkg::SUM_W)'(0), in_s});

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cand_p[k] = in_p[k] + (in_q[k] <<< (BIT_POS + 2)) + (s_ext <<< (2 * BIT_POS + 2));
         if (cand_p[k] <= $signed({(PW + 1 - TW)'(0), in_t[k]})) begin
            next_p[k] = cand_p[k];
            next_q[k] = in_q[k] + (s_ext <<< (BIT_POS + 1));
            next_r[k] = in_r[k] | (RW'(1) << BIT_POS);
         end else begin
            next_p[k] = in_p[k];
            next_q[k] = in_q[k];
            next_r[k] = in_r[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= in_valid;
      end
      if (adv) begin
         out_s   <= in_s;
         out_neg <= in_neg;
         out_t   <= in_t;
         out_p   <= next_p;
         out_q   <= next_q;
         out_r   <= next_r;
         out_idx <= in_idx;
      end
   end
endmodule
`default_nettype wire

>>> hdl/cube_sphere_vertex_and_index_gen.sv
// Cube-sphere vertex and index generator, top level.
// Positions are signed Q1.15 at the default COORD_FRAC_BITS.
// Throughput: one transaction per cycle while rsp_stall is low; each bit of the normalize search has its own stage.
// A stalled result holds its stage; bubbles ahead of it still fill up.
// Reset is synchronous: clears all valid bits and sets the resolution register to 16.
// Depends on csvig_pkg, csvig_front, csvig_norm_stage and the macros header.
`default_nettype none
`include "cube_sphere_vertex_and_index_gen_macros.svh"
module cube_sphere_vertex_and_index_gen #(
   parameter int MAX_RESOLUTION  = csvig_pkg::MAX_RESOLUTION_DEFAULT,
   parameter int COORD_FRAC_BITS = csvig_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire csvig_pkg::req_type           req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output csvig_pkg::rsp_type                rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [csvig_pkg::RES_W-1:0]  csr_data
);
   localparam int F  = COORD_FRAC_BITS;
   localparam int TW = csvig_pkg::SQ_W + 2 * F + 2;
   localparam int PW = 2 * F + 26;
   localparam int RW = F + 1;
   localparam int NS = F + 1;   // search stages, one per result bit

   // ---- configuration register ----
   logic [csvig_pkg::RES_W-1:0] res_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= csvig_pkg::RESOLUTION_RESET;
      end else if (csr_valid && csr_ready) begin
         res_ff <= csr_data;
      end
   end

   // ---- front end ----
   logic                                 fr_valid, fr_ready, fr_in_ready;
   logic [csvig_pkg::SUM_W-1:0]          fr_s;
   logic [2:0]                           fr_neg;
   logic [2:0][TW-1:0]                   fr_t;
   csvig_pkg::idx_type                   fr_idx;

   csvig_front #(
      .MAX_RESOLUTION (MAX_RESOLUTION),
      .COORD_FRAC_BITS(F)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_data  (req_data),
      .in_ready (fr_in_ready),
      .res      (res_ff),
      .out_valid(fr_valid),
      .out_s    (fr_s),
      .out_neg  (fr_neg),
      .out_t    (fr_t),
      .out_idx  (fr_idx),
      .out_ready(fr_ready)
   );
   assign req_stall = !fr_in_ready;

   // ---- normalize search chain, MSB first ----
   // entry k feeds stage k; entry NS is the chain's output
   logic [NS:0]                          ch_valid, ch_ready;
   logic [NS:0][csvig_pkg::SUM_W-1:0]    ch_s;
   logic [NS:0][2:0]                     ch_neg;
   logic [NS:0][2:0][TW-1:0]             ch_t;
   logic signed [NS:0][2:0][PW:0]        ch_p, ch_q;
   logic [NS:0][2:0][RW-1:0]             ch_r;
   csvig_pkg::idx_type [NS:0]            ch_idx;
   logic signed [PW:0]                   s_wide;

   // search starts at r = 0, i.e. (2r-1) = -1: P = S, Q = -S
   assign s_wide      = $signed({(PW + 1 - csvig_pkg::SUM_W)'(0), fr_s});
   assign ch_valid[0] = fr_valid;
   assign ch_s[0]     = fr_s;
   assign ch_neg[0]   = fr_neg;
   assign ch_t[0]     = fr_t;
   assign ch_idx[0]   = fr_idx;
   assign ch_p[0]     = {3{s_wide}};
   assign ch_q[0]     = {3{-s_wide}};
   assign ch_r[0]     = '0;
   assign fr_ready    = ch_ready[0];

   for (genvar g = 0; g < NS; g++) begin : g_search
      csvig_norm_stage #(
         .COORD_FRAC_BITS(F),
         .BIT_POS        (F - g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (ch_valid[g]),
         .in_ready (ch_ready[g]),
         .in_s     (ch_s[g]),
         .in_neg   (ch_neg[g]),
         .in_t     (ch_t[g]),
         .in_p     (ch_p[g]),
         .in_q     (ch_q[g]),
         .in_r     (ch_r[g]),
         .in_idx   (ch_idx[g]),
         .out_valid(ch_valid[g+1]),
         .out_ready(ch_ready[g+1]),
         .out_s    (ch_s[g+1]),
         .out_neg  (ch_neg[g+1]),
         .out_t    (ch_t[g+1]),
         .out_p    (ch_p[g+1]),
         .out_q    (ch_q[g+1]),
         .out_r    (ch_r[g+1]),
         .out_idx  (ch_idx[g+1])
      );
   end

   // ---- output register: sign, saturation of +1, mask to 16 bits ----
   localparam logic [31:0] POS_TOP = (32'd1 << F) - 32'd1;
   logic out_adv;
   logic [2:0][csvig_pkg::POS_W-1:0] pos_c;
   logic [31:0] mag_w;

   assign out_adv = !rsp_valid || !rsp_stall;
   assign ch_ready[NS] = out_adv;

   always_comb begin
      mag_w = '0;
      for (int k = 0; k < 3; k++) begin
         mag_w = 32'(ch_r[NS][k]);
         if (ch_neg[NS][k]) begin
            mag_w = 32'd0 - mag_w;
         end else if (mag_w > POS_TOP) begin
            mag_w = POS_TOP;
         end
         pos_c[k] = mag_w[csvig_pkg::POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_adv) begin
         rsp_valid <= ch_valid[NS];
      end
      if (out_adv) begin
         rsp_data.pos_x      <= $signed(pos_c[0]);
         rsp_data.pos_y      <= $signed(pos_c[1]);
         rsp_data.pos_z      <= $signed(pos_c[2]);
         rsp_data.quad_valid <= ch_idx[NS].quad_valid;
         rsp_data.tri_a0     <= ch_idx[NS].tri_a0;
         rsp_data.tri_a1     <= ch_idx[NS].tri_a1;
         rsp_data.tri_a2     <= ch_idx[NS].tri_a2;
         rsp_data.tri_b0     <= ch_idx[NS].tri_b0;
         rsp_data.tri_b1     <= ch_idx[NS].tri_b1;
         rsp_data.tri_b2     <= ch_idx[NS].tri_b2;
      end
   end

   // ---- assertions ----
   // no-quad transactions carry zero indices (checked on tri_a0, tri_b1 and tri_a2)
   `CSVIG_ASSERT_IMP(a_noquad_zero, rsp_valid && !rsp_data.quad_valid, (rsp_data.tri_a0 == 0) && (rsp_data.tri_b1 == 0) && (rsp_data.tri_a2 == 0))
   // both triangles share the corner vertex
   `CSVIG_ASSERT_IMP(a_shared_corner, rsp_valid && rsp_data.quad_valid, rsp_data.tri_a0 == rsp_data.tri_b0)
   // the fixed axis is at least 1/sqrt(3), so a vertex is never the origin
   `CSVIG_ASSERT_IMP(a_not_origin, rsp_valid, (rsp_data.pos_x != 0) || (rsp_data.pos_y != 0) || (rsp_data.pos_z != 0))
   // a result that is stalled stays in the output register
   `CSVIG_ASSERT_NXT(a_stall_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
endmodule
`default_nettype wire

>>> dv/csvig_checker.sv
// Result checker for the cube-sphere vertex and index generator.
// Watches request, response and register channels; depends on csvig_pkg.
`timescale 1ns / 100ps
`default_nettype none
module csvig_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire csvig_pkg::req_type            req_data,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire csvig_pkg::rsp_type            rsp_data,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [csvig_pkg::RES_W-1:0]   csr_data,
   output int                                 fail_count,
   output int                                 pending
);
   localparam int FB = csvig_pkg::COORD_FRAC_BITS_DEFAULT;
   localparam int PW = csvig_pkg::POS_W;
   localparam int XW = csvig_pkg::IDX_W;

   logic [csvig_pkg::RES_W-1:0] resolution;
   csvig_pkg::rsp_type          vertex_queue[$];

   // magnitude search: largest q with (2q-1)^2 * sumsq <= 4 * mag^2 * 2^(2F)
   function automatic logic [PW-1:0] unit_component(longint num, longint sumsq);
      longint mag, q, cand, odd;
      logic [127:0] lhs, rhs;
      mag = (num < 0) ? -num : num;
      rhs = (128'(mag * mag) * 4) << (2 * FB);
      q = 0;
      for (int b = FB; b >= 0; b--) begin
         cand = q | (64'd1 << b);
         odd  = 2 * cand - 1;
         lhs  = 128'(odd * odd) * 128'(sumsq);
         if (lhs <= rhs) q = cand;
      end
      if (num >= 0) begin
         if (q > (64'd1 << FB) - 1) q = (64'd1 << FB) - 1;
         return q[PW-1:0];
      end
      return PW'(-q);
   endfunction

   function automatic csvig_pkg::rsp_type predict_vertex(csvig_pkg::req_type rq,
                                                         logic [csvig_pkg::RES_W-1:0] reg_res);
      csvig_pkg::rsp_type r;
      longint res, face, col, row, d, a, b, vx, vy, vz, sumsq, n;
      logic inverted;
      res  = reg_res;
      face = rq.face;
      col  = rq.col;
      row  = rq.row;
      if (res < csvig_pkg::RESOLUTION_MIN) res = csvig_pkg::RESOLUTION_MIN;
      if (res > csvig_pkg::MAX_RESOLUTION_DEFAULT) res = csvig_pkg::MAX_RESOLUTION_DEFAULT;
      if (face > csvig_pkg::FACE_NEG_X) face = csvig_pkg::FACE_POS_Z;
      d = res - 1;
      if (col > d) col = d;
      if (row > d) row = d;
      a = 2 * col - d;
      b = 2 * row - d;
      case (face)
         csvig_pkg::FACE_NEG_Z: begin vx = a;  vy = b;  vz = -d; end
         csvig_pkg::FACE_POS_Y: begin vx = a;  vy = d;  vz = b;  end
         csvig_pkg::FACE_NEG_Y: begin vx = a;  vy = -d; vz = b;  end
         csvig_pkg::FACE_POS_X: begin vx = d;  vy = b;  vz = a;  end
         csvig_pkg::FACE_NEG_X: begin vx = -d; vy = b;  vz = a;  end
         default:               begin vx = a;  vy = b;  vz = d;  end
      endcase
      sumsq = vx * vx + vy * vy + vz * vz;
      r = '0;
      r.pos_x = unit_component(vx, sumsq);
      r.pos_y = unit_component(vy, sumsq);
      r.pos_z = unit_component(vz, sumsq);
      if (col < d && row < d) begin
         n = face * res * res + row * res + col;
         inverted = (face == csvig_pkg::FACE_NEG_Z || face == csvig_pkg::FACE_POS_Y
                     || face == csvig_pkg::FACE_POS_X);
         r.quad_valid = 1'b1;
         r.tri_a0 = XW'(n);
         r.tri_b0 = XW'(n);
         r.tri_a1 = XW'(inverted ? n + res + 1 : n + res);
         r.tri_a2 = XW'(inverted ? n + res : n + res + 1);
         r.tri_b1 = XW'(inverted ? n + 1 : n + res + 1);
         r.tri_b2 = XW'(inverted ? n + res + 1 : n + 1);
      end
      return r;
   endfunction

   task automatic compare_field(string name, longint expd, longint act);
      if (expd != act) begin
         $display("%0t: mismatch %s expected %0h actual %0h", $time, name, expd, act);
         fail_count++;
      end
   endtask

   assign pending = vertex_queue.size();

   always @(posedge clock) begin
      csvig_pkg::rsp_type e;
      if (reset) begin
         resolution <= csvig_pkg::RESOLUTION_RESET;
         fail_count <= 0;
         vertex_queue.delete();
      end else begin
         if (req_valid && !req_stall)
            vertex_queue.push_back(predict_vertex(req_data, resolution));
         if (csr_valid && csr_ready) resolution <= csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (vertex_queue.size() == 0) begin
               $display("%0t: unexpected result %0h", $time, rsp_data);
               fail_count++;
            end else begin
               e = vertex_queue.pop_front();
               compare_field("pos_x", e.pos_x, rsp_data.pos_x);
               compare_field("pos_y", e.pos_y, rsp_data.pos_y);
               compare_field("pos_z", e.pos_z, rsp_data.pos_z);
               compare_field("quad_valid", e.quad_valid, rsp_data.quad_valid);
               compare_field("tri_a0", e.tri_a0, rsp_data.tri_a0);
               compare_field("tri_a1", e.tri_a1, rsp_data.tri_a1);
               compare_field("tri_a2", e.tri_a2, rsp_data.tri_a2);
               compare_field("tri_b0", e.tri_b0, rsp_data.tri_b0);
               compare_field("tri_b1", e.tri_b1, rsp_data.tri_b1);
               compare_field("tri_b2", e.tri_b2, rsp_data.tri_b2);
            end
         end
      end
   end
endmodule
`default_nettype wire

>>> dv/tb_cube_sphere_vertex_and_index_gen.sv
// Testbench top for the cube-sphere vertex and index generator.
// Drives grid points and register writes; csvig_checker predicts and compares.
`timescale 1ns / 100ps
`default_nettype none
module tb_cube_sphere_vertex_and_index_gen;
   localparam int LATENCY    = csvig_pkg::COORD_FRAC_BITS_DEFAULT + 5;
   localparam int IDLE_LIMIT = 5000;   // cycles with no transaction at all
   localparam int FW = csvig_pkg::FACE_W;
   localparam int GW = csvig_pkg::GRID_W;
   localparam int RW = csvig_pkg::RES_W;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   csvig_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   csvig_pkg::rsp_type rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [RW-1:0]      csr_data = '0;
   int                 fail_count;
   int                 pending;
   int                 idle_cycles = 0;
   int                 stall_mode = 0;

   cube_sphere_vertex_and_index_gen dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   csvig_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver stall pattern: phases of none, light, heavy, periodic
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 7) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ($time / 8) % 3 == 0;
      endcase
   end

   // watchdog on transaction activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** cube_sphere_vertex_and_index_gen: FAILED **");
         $finish;
      end
   end

   // one grid point; holds valid across back-to-back transactions,
   // otherwise drops valid for at least one cycle
   task automatic send_point(logic [FW-1:0] f, logic [GW-1:0] c,
                             logic [GW-1:0] r, bit keep_valid);
      req_valid <= 1'b1;
      req_data  <= '{face: f, col: c, row: r};
      do @(posedge clock); while (req_stall);
      if (!keep_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // register write only when the pipeline has drained
   task automatic write_resolution(logic [RW-1:0] value);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // random point: mostly on the grid, some beyond it, faces 6/7 now and then
   task automatic random_points(int count, logic [RW-1:0] res);
      int burst;
      int lim;
      logic [GW-1:0] c, r;
      lim = (res > 256) ? 255 : ((res < 2) ? 1 : int'(res) - 1);
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && count > 0) begin
            if ($urandom_range(0, 9) == 0) begin
               c = GW'($urandom); r = GW'($urandom);
            end else begin
               c = GW'($urandom_range(0, lim)); r = GW'($urandom_range(0, lim));
            end
            send_point(FW'($urandom_range(0, 7)), c, r, burst > 1 && count > 1);
            burst--; count--;
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   initial begin
      logic [RW-1:0] settings[6];
      int waited;
      settings = '{9'd256, 9'd2, 9'd0, 9'd511, 9'd3, 9'd97};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed at reset resolution 16: corners, centers, every face, clamps
      for (int f = 0; f < 8; f++) send_point(FW'(f), 0, 0, 1);
      send_point(csvig_pkg::FACE_POS_Z, 15, 15, 1);
      send_point(csvig_pkg::FACE_NEG_X, 14, 14, 1);
      send_point(csvig_pkg::FACE_POS_X, 14, 0, 1);
      send_point(csvig_pkg::FACE_NEG_Y, 0, 15, 1);
      send_point(csvig_pkg::FACE_POS_Y, 255, 255, 1);
      send_point(csvig_pkg::FACE_NEG_Z, 8, 200, 1);
      send_point(csvig_pkg::FACE_POS_X, 7, 8, 1);
      send_point(3'd7, 255, 0, 0);

      random_points(100, 9'd16);
      foreach (settings[i]) begin
         write_resolution(settings[i]);
         if (settings[i] == 9'd256) begin
            send_point(csvig_pkg::FACE_NEG_X, 255, 255, 1);
            send_point(csvig_pkg::FACE_NEG_X, 254, 254, 1);
            send_point(csvig_pkg::FACE_POS_Z, 128, 127, 0);
         end
         random_points(80, settings[i]);
      end

      waited = 0;
      while (pending != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** cube_sphere_vertex_and_index_gen: PASSED **");
      else
         $display("** cube_sphere_vertex_and_index_gen: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
